FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro takes a label, the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define ECSFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, switched off while reset is low.
`define ECSFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/ecsfp_pkg.sv
// Shared constants, types and counter helpers for the sample FIFO player.
// No dependencies; imported by the top level and the checker.
package ecsfp_pkg;

  localparam int DEPTH        = 1024;
  localparam int PACKET_BYTES = 64;
  localparam int CHANNELS     = 8;

  localparam int CNT_W     = $clog2(2 * DEPTH);
  localparam int POS_W     = $clog2(PACKET_BYTES);
  localparam int CH_W      = 3;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_DEPTH = CHANNELS * DEPTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [7:0] HDR0 = 8'd31;
  localparam logic [7:0] HDR1 = 8'd97;
  localparam logic [7:0] HDR2 = 8'd52;
  localparam logic [7:0] HDR3 = 8'd73;

  localparam logic [CNT_W:0]   SPAN      = (CNT_W + 1)'(2 * DEPTH);
  localparam logic [CNT_W:0]   FULL_FILL = (CNT_W + 1)'(DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);
  localparam logic [7:0]       CH_MAX    = 8'(CHANNELS);

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CH_W-1:0]  ch_t;

  // Ring counters run modulo twice the ring depth so that full and empty differ.
  function automatic cnt_t cnt_next(cnt_t c);
    logic [CNT_W:0] s;
    s = {1'b0, c} + 1'b1;
    return (s >= SPAN) ? '0 : s[CNT_W-1:0];
  endfunction

  function automatic logic [CNT_W:0] fill_of(cnt_t w, cnt_t r);
    logic [CNT_W:0] wx;
    logic [CNT_W:0] rx;
    wx = {1'b0, w};
    rx = {1'b0, r};
    return (wx >= rx) ? (wx - rx) : (wx + SPAN - rx);
  endfunction

  // Store address of a channel's ring slot; the counter is below twice the depth.
  function automatic logic [MEM_AW-1:0] mem_addr(ch_t ch, cnt_t c);
    cnt_t            p;
    logic [MEM_AW:0] a;
    p = (c >= DEPTH_C) ? (c - DEPTH_C) : c;
    a = (MEM_AW + 1)'(ch) * (MEM_AW + 1)'(DEPTH) + (MEM_AW + 1)'(p);
    return a[MEM_AW-1:0];
  endfunction

endpackage

FILE: rtl/ecsfp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; read data holds until the next read is issued.
module ecsfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/eight_channel_sample_fifo_player.sv
// Eight-channel sample FIFO player: top level.
// Depends on ecsfp_pkg and ecsfp_ram.
//
// The input channel carries one word per handshake. With in_func low the word is a
// packet byte: packets are PACKET_BYTES long, start with the header 31, 97, 52, 73,
// name a channel from 1 to CHANNELS in byte 4 and carry samples in the remaining
// bytes, which are appended to that channel's ring in the sample store. Packets
// with a bad header or an unknown channel (the carrier command 99 included) are
// ignored. With in_func high the word is a sample of the strobe pin; on a rising
// edge every nonempty channel pops one sample, in channel order, and each is sent
// on the output channel as a played level, the final one flagged by out_last.
// A sample that arrives for a full ring is dropped and reported as a kind 1 word.
// Packet bytes are taken one per cycle while the block is idle and the output
// register is free; a dropped byte is reported in the cycle after it is taken. On
// a strobe edge each nonempty channel, up to CHANNELS of them, is popped by a read
// of the single-port-read sample store in S_READ followed by a load of the output
// register in S_LOAD, where the word read in S_READ becomes the played word.
// When the receiver stalls the output register holds its word and in_ready stays
// low until the register can take a new one. Reset empties all rings, clears the
// packet framing and the strobe history; the store itself needs no clearing.
module eight_channel_sample_fifo_player import ecsfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_func,
  input  logic [7:0] in_data,
  input  logic       in_packet_start,
  input  logic       in_strobe_level,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [2:0] out_channel,
  output logic [7:0] out_level,
  output logic       out_last
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LOAD} state_t;

  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 hdr_good_r, hdr_good_nxt;
  logic                 pkt_ok_r, pkt_ok_nxt;
  ch_t                  pkt_ch_r, pkt_ch_nxt;
  logic                 prev_strobe_r, prev_strobe_nxt;
  cnt_t                 wcnt_r [CHANNELS];
  cnt_t                 wcnt_nxt [CHANNELS];
  cnt_t                 rcnt_r [CHANNELS];
  cnt_t                 rcnt_nxt [CHANNELS];
  logic [CHANNELS-1:0]  mask_r, mask_nxt;
  ch_t                  scan_ch_r, scan_ch_nxt;
  logic                 scan_last_r, scan_last_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_kind_r, out_kind_nxt;
  ch_t                  out_channel_r, out_channel_nxt;
  logic [7:0]           out_level_r, out_level_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 in_fire;
  logic                 out_free;
  logic [POS_W-1:0]     pos;
  ch_t                  pick_ch;
  logic [CHANNELS-1:0]  rest_mask;
  logic [CHANNELS-1:0]  nonempty;
  ch_t                  sel_ch;
  logic [CH_IDX_W-1:0]  sel_idx;
  cnt_t                 wc_sel;
  cnt_t                 rc_sel;
  logic                 ram_wr_en;
  logic [MEM_AW-1:0]    ram_wr_addr;
  logic                 ram_rd_en;
  logic [MEM_AW-1:0]    ram_rd_addr;
  logic [7:0]           ram_rd_data;

  // One byte-wide store holds all rings, channel-major. Writes happen only on
  // packet bytes in idle and reads only during a pop sweep, so they never meet.
  ecsfp_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (in_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_channel = out_channel_r;
  assign out_level   = out_level_r;
  assign out_last    = out_last_r;

  assign pos = in_packet_start ? '0 : pos_r;

  // Lowest pending channel of the sweep, and the mask with it removed.
  always_comb begin
    pick_ch   = '0;
    rest_mask = mask_r;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick_ch = CH_W'(i);
      end
    end
    rest_mask[pick_ch[CH_IDX_W-1:0]] = 1'b0;
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      nonempty[i] = (wcnt_r[i] != rcnt_r[i]);
    end
  end

  // The counter files are looked up at one channel per cycle: the packet's
  // channel while idle, the swept channel otherwise.
  assign sel_ch  = (state_r == S_IDLE) ? pkt_ch_r : pick_ch;
  assign sel_idx = sel_ch[CH_IDX_W-1:0];
  assign wc_sel  = wcnt_r[sel_idx];
  assign rc_sel  = rcnt_r[sel_idx];

  assign ram_wr_addr = mem_addr(pkt_ch_r, wc_sel);
  assign ram_rd_addr = mem_addr(pick_ch, rc_sel);

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    hdr_good_nxt    = hdr_good_r;
    pkt_ok_nxt      = pkt_ok_r;
    pkt_ch_nxt      = pkt_ch_r;
    prev_strobe_nxt = prev_strobe_r;
    wcnt_nxt        = wcnt_r;
    rcnt_nxt        = rcnt_r;
    mask_nxt        = mask_r;
    scan_ch_nxt     = scan_ch_r;
    scan_last_nxt   = scan_last_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_kind_nxt    = out_kind_r;
    out_channel_nxt = out_channel_r;
    out_level_nxt   = out_level_r;
    out_last_nxt    = out_last_r;
    ram_wr_en       = 1'b0;
    ram_rd_en       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && !in_func) begin
          pos_nxt = (pos == POS_LAST) ? '0 : pos + 1'b1;
          if (pos == POS_W'(0)) begin
            hdr_good_nxt = (in_data == HDR0);
          end else if (pos == POS_W'(1)) begin
            hdr_good_nxt = hdr_good_r && (in_data == HDR1);
          end else if (pos == POS_W'(2)) begin
            hdr_good_nxt = hdr_good_r && (in_data == HDR2);
          end else if (pos == POS_W'(3)) begin
            hdr_good_nxt = hdr_good_r && (in_data == HDR3);
          end else if (pos == POS_W'(4)) begin
            pkt_ok_nxt = hdr_good_r && (in_data >= 8'd1) && (in_data <= CH_MAX);
            pkt_ch_nxt = CH_W'(in_data - 8'd1);
          end else if (hdr_good_r && pkt_ok_r) begin
            if (fill_of(wc_sel, rc_sel) < FULL_FILL) begin
              ram_wr_en         = 1'b1;
              wcnt_nxt[sel_idx] = cnt_next(wc_sel);
            end else begin
              out_valid_nxt   = 1'b1;
              out_kind_nxt    = 1'b1;
              out_channel_nxt = pkt_ch_r;
              out_level_nxt   = in_data;
              out_last_nxt    = 1'b1;
            end
          end
        end else if (in_fire) begin
          prev_strobe_nxt = in_strobe_level;
          if (in_strobe_level && !prev_strobe_r) begin
            mask_nxt = nonempty;
            if (|nonempty) begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        ram_rd_en         = 1'b1;
        rcnt_nxt[sel_idx] = cnt_next(rc_sel);
        scan_ch_nxt       = pick_ch;
        scan_last_nxt     = (rest_mask == '0);
        mask_nxt          = rest_mask;
        state_nxt         = S_LOAD;
      end
      S_LOAD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_kind_nxt    = 1'b0;
          out_channel_nxt = scan_ch_r;
          out_level_nxt   = ram_rd_data;
          out_last_nxt    = scan_last_r;
          state_nxt       = (mask_r == '0) ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pos_r         <= '0;
      hdr_good_r    <= 1'b1;
      pkt_ok_r      <= 1'b0;
      pkt_ch_r      <= '0;
      prev_strobe_r <= 1'b0;
      mask_r        <= '0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        wcnt_r[i] <= '0;
        rcnt_r[i] <= '0;
      end
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      hdr_good_r    <= hdr_good_nxt;
      pkt_ok_r      <= pkt_ok_nxt;
      pkt_ch_r      <= pkt_ch_nxt;
      prev_strobe_r <= prev_strobe_nxt;
      mask_r        <= mask_nxt;
      out_valid_r   <= out_valid_nxt;
      wcnt_r        <= wcnt_nxt;
      rcnt_r        <= rcnt_nxt;
    end
    scan_ch_r     <= scan_ch_nxt;
    scan_last_r   <= scan_last_nxt;
    out_kind_r    <= out_kind_nxt;
    out_channel_r <= out_channel_nxt;
    out_level_r   <= out_level_nxt;
    out_last_r    <= out_last_nxt;
  end

endmodule

FILE: rtl/ecsfp_checker.sv
// Port-level checker for the sample FIFO player, bound to its top level.
// Depends on ecsfp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ecsfp_checker import ecsfp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_kind,
  input logic [2:0] out_channel,
  input logic       out_last
);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // A stalled output word stays offered.
  `ECSFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A dropped byte is always the only word of its input.
  `ECSFP_ASSERT_IMPLY(a_drop_is_last, clk, rst_n, out_valid && out_kind, out_last)

  // While a pop sweep is still delivering, no new word may be taken.
  `ECSFP_ASSERT_IMPLY(a_sweep_blocks_input, clk, rst_n,
                      out_valid && !out_kind && !out_last, !in_fire)

  // Only configured channels are reported.
  `ECSFP_ASSERT_IMPLY(a_channel_range, clk, rst_n, out_valid, int'(out_channel) < CHANNELS)

endmodule

bind eight_channel_sample_fifo_player ecsfp_checker u_ecsfp_checker (.*);
